// ===== rtl/mvpa_pkg.sv =====
// mvpa_pkg: shared types, codes and tables for the voice allocator
// no dependencies; used by all files in rtl/

package mvpa_pkg;

	// command codes
	localparam logic CMD_NOTE_ON  = 1'b0;
	localparam logic CMD_NOTE_OFF = 1'b1;

	// result event codes
	typedef enum logic [2:0] {
		EV_STARTED   = 3'd0,
		EV_RELEASED  = 3'd1,
		EV_OUT_VOICE = 3'd2,
		EV_TOO_HIGH  = 3'd3,
		EV_NO_VOICE  = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_COMMIT
	} state_t;

	// midi note offset applied to every item
	localparam int unsigned NOTE_OFFSET = 3;

	// ascii characters used in the report
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_DASH  = 7'h2d;
	localparam logic [6:0] CH_ZERO  = 7'h30;

	// 2^(s/12) in unsigned q8.24
	localparam logic [31:0] SEMI [12] = '{
		32'd16777216, 32'd17774841, 32'd18831788, 32'd19951585,
		32'd21137968, 32'd22394897, 32'd23726566, 32'd25137421,
		32'd26632170, 32'd28215802, 32'd29893600, 32'd31671166
	};

	// note name characters per semitone (a at semitone zero)
	localparam logic [6:0] NAME_A [12] = '{
		7'h20, 7'h61, 7'h20, 7'h20, 7'h63, 7'h20,
		7'h64, 7'h20, 7'h20, 7'h66, 7'h20, 7'h67
	};
	localparam logic [6:0] NAME_B [12] = '{
		7'h61, 7'h23, 7'h62, 7'h63, 7'h23, 7'h64,
		7'h23, 7'h65, 7'h66, 7'h23, 7'h67, 7'h23
	};

	// control handed to every voice cell
	typedef struct packed {
		logic       find_free;  // 1: search free voice, 0: search matching note
		logic [7:0] n;          // offset note
		logic       claim;      // mark selected voice busy with n
		logic       drop;       // free selected voice
	} cell_ctrl_t;

endpackage

// ===== rtl/midi_poly_voice_allocator_core.sv =====
// midi_poly_voice_allocator_core: top level of the polyphonic voice allocator
// depends on mvpa_pkg, mvpa_freq_rom and mvpa_voice_cell
//
// usage
//  - an item (cmd, note) is taken at a rising edge with start high and busy low
//  - note-on takes the lowest free voice, note-off frees the lowest busy voice
//    holding the same note; the note is offset by 3 before anything else
//  - each item gives exactly one result, shown for one cycle with done high;
//    the receiver cannot stall, so results are never held back
//  - an item passes the look state (registered table read) and then the
//    commit state, which updates the voice chain; busy is high in both, so
//    a new item is taken only after the last one is through
//  - the voices form a chain of cells; a search flag ripples from voice 0
//    upward so the lowest matching voice wins
//  - cfg_we writes cfg_data into the video standard bit (0 pal, 1 ntsc);
//    write it only while the block is idle
//  - reset frees every voice, clears the out-of-voices flag and selects pal

module midi_poly_voice_allocator_core #(
	parameter int unsigned VOICES        = 3,
	parameter int unsigned PAL_CLOCK_HZ  = 985248,
	parameter int unsigned NTSC_CLOCK_HZ = 1022727
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [6:0]  note,
	output logic        done,
	output logic [2:0]  event_res,
	output logic [1:0]  voice,
	output logic [15:0] freq_word,
	output logic        gate,
	output logic [6:0]  name_first,
	output logic [6:0]  name_second,
	output logic [6:0]  octave_char,
	output logic        out_of_voices
);

	localparam int unsigned VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

	mvpa_pkg::state_t state_q, state_d;

	logic       std_q;        // video standard register
	logic       pool_full_q;  // sticky out-of-voices flag
	logic       cmd_q;
	logic [6:0] note_q;
	logic [7:0] n_off;        // offset note held by the current item

	// table outputs, valid in the commit cycle
	logic [15:0] rom_word;
	logic        rom_too_high;
	logic [6:0]  rom_first;
	logic [6:0]  rom_second;
	logic [6:0]  rom_octave;

	mvpa_pkg::cell_ctrl_t ctrl;
	logic [VOICES:0]      found;
	logic [VOICES-1:0]    hit;
	logic [VIDX_W-1:0]    hit_idx;
	logic                 any_hit;

	assign busy  = (state_q != mvpa_pkg::ST_IDLE);
	assign n_off = {1'b0, note_q} + 8'(mvpa_pkg::NOTE_OFFSET);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_q <= 1'b0;
		end else if (cfg_we) begin
			std_q <= cfg_data;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q  <= cmd;
			note_q <= note;
		end
	end

	// oscillator word and note name lookup, registered read
	mvpa_freq_rom #(
		.PAL_CLOCK_HZ  (PAL_CLOCK_HZ),
		.NTSC_CLOCK_HZ (NTSC_CLOCK_HZ)
	) u_rom (
		.clk        (clk),
		.std_sel    (std_q),
		.note       (note_q),
		.word_q     (rom_word),
		.too_high_q (rom_too_high),
		.first_q    (rom_first),
		.second_q   (rom_second),
		.octave_q   (rom_octave)
	);

	// voice chain: found ripples from voice 0 so the lowest candidate takes the hit
	assign found[0] = 1'b0;
	for (genvar v = 0; v < VOICES; v++) begin : g_voice
		mvpa_voice_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.found_in  (found[v]),
			.found_out (found[v+1]),
			.hit       (hit[v])
		);
	end
	assign any_hit = found[VOICES];

	// one-hot hit to index, at most one bit is set
	always_comb begin
		hit_idx = '0;
		for (int v = 0; v < VOICES; v++) begin
			if (hit[v]) begin
				hit_idx = hit_idx | VIDX_W'(v);
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mvpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and chain control
	always_comb begin
		state_d        = state_q;
		ctrl.find_free = (cmd_q == mvpa_pkg::CMD_NOTE_ON);
		ctrl.n         = n_off;
		ctrl.claim     = 1'b0;
		ctrl.drop      = 1'b0;
		case (state_q)
			mvpa_pkg::ST_IDLE: begin
				if (start) begin
					state_d = mvpa_pkg::ST_LOOK;
				end
			end
			mvpa_pkg::ST_LOOK: begin
				state_d = mvpa_pkg::ST_COMMIT;
			end
			mvpa_pkg::ST_COMMIT: begin
				// a word above range leaves every voice untouched
				ctrl.claim = (cmd_q == mvpa_pkg::CMD_NOTE_ON) && !rom_too_high;
				ctrl.drop  = (cmd_q == mvpa_pkg::CMD_NOTE_OFF);
				state_d    = mvpa_pkg::ST_IDLE;
			end
			default: begin
				state_d = mvpa_pkg::ST_IDLE;
			end
		endcase
	end

	// result register and sticky flag, updated in the commit cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done          <= 1'b0;
			pool_full_q   <= 1'b0;
			event_res     <= mvpa_pkg::EV_STARTED;
			voice         <= '0;
			freq_word     <= '0;
			gate          <= 1'b0;
			name_first    <= '0;
			name_second   <= '0;
			octave_char   <= '0;
			out_of_voices <= 1'b0;
		end else begin
			done <= (state_q == mvpa_pkg::ST_COMMIT);
			if (state_q == mvpa_pkg::ST_COMMIT) begin
				voice       <= '0;
				freq_word   <= '0;
				gate        <= 1'b0;
				name_first  <= '0;
				name_second <= '0;
				octave_char <= '0;
				if (cmd_q == mvpa_pkg::CMD_NOTE_ON) begin
					out_of_voices <= pool_full_q;
					if (!any_hit) begin
						// pool full
						event_res     <= mvpa_pkg::EV_OUT_VOICE;
						pool_full_q   <= 1'b1;
						out_of_voices <= 1'b1;
					end else if (rom_too_high) begin
						event_res <= mvpa_pkg::EV_TOO_HIGH;
					end else begin
						event_res   <= mvpa_pkg::EV_STARTED;
						voice       <= 2'(hit_idx);
						freq_word   <= rom_word;
						gate        <= 1'b1;
						name_first  <= rom_first;
						name_second <= rom_second;
						octave_char <= rom_octave;
					end
				end else begin
					// every note-off clears the flag
					pool_full_q   <= 1'b0;
					out_of_voices <= 1'b0;
					if (!any_hit) begin
						event_res <= mvpa_pkg::EV_NO_VOICE;
					end else begin
						event_res   <= mvpa_pkg::EV_RELEASED;
						voice       <= 2'(hit_idx);
						name_first  <= mvpa_pkg::CH_DASH;
						name_second <= mvpa_pkg::CH_DASH;
						octave_char <= mvpa_pkg::CH_SPACE;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/mvpa_voice_cell.sv =====
// mvpa_voice_cell: one voice slot of the allocation chain
// depends on mvpa_pkg (cell_ctrl_t)

module mvpa_voice_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mvpa_pkg::cell_ctrl_t ctrl,
	input  logic                 found_in,
	output logic                 found_out,
	output logic                 hit
);

	logic       busy_q;
	logic [7:0] note_q;
	logic       cand;

	// candidate: free slot for note-on, busy slot with same note for note-off
	assign cand      = ctrl.find_free ? !busy_q : (busy_q && (note_q == ctrl.n));
	assign hit       = cand && !found_in;
	assign found_out = found_in || cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (hit && ctrl.claim) begin
			busy_q <= 1'b1;
		end else if (hit && ctrl.drop) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && ctrl.claim) begin
			note_q <= ctrl.n;
		end
	end

endmodule

// ===== rtl/mvpa_freq_rom.sv =====
// mvpa_freq_rom: per-note oscillator word and note name table, registered read
// depends on mvpa_pkg (SEMI, NAME_A, NAME_B, NOTE_OFFSET, character constants)

module mvpa_freq_rom #(
	parameter int unsigned PAL_CLOCK_HZ  = 985248,
	parameter int unsigned NTSC_CLOCK_HZ = 1022727
) (
	input  logic        clk,
	input  logic        std_sel,
	input  logic [6:0]  note,
	output logic [15:0] word_q,
	output logic        too_high_q,
	output logic [6:0]  first_q,
	output logic [6:0]  second_q,
	output logic [6:0]  octave_q
);

	localparam logic [63:0] DEN_PAL  = 64'd32 * 64'(PAL_CLOCK_HZ);
	localparam logic [63:0] DEN_NTSC = 64'd32 * 64'(NTSC_CLOCK_HZ);

	// bit 16 set means word above 0xffff
	logic [16:0] word_pal  [128];
	logic [16:0] word_ntsc [128];
	logic [6:0]  first_tab [128];
	logic [6:0]  second_tab [128];
	logic [6:0]  octave_tab [128];

	for (genvar i = 0; i < 128; i++) begin : g_ent
		localparam int unsigned N  = i + mvpa_pkg::NOTE_OFFSET;
		localparam int unsigned Q  = N / 12;
		localparam int unsigned S  = N % 12;
		localparam logic [63:0] NUM = (64'd440 * 64'(mvpa_pkg::SEMI[S])) << Q;
		localparam logic [63:0] WP = NUM / DEN_PAL;
		localparam logic [63:0] WN = NUM / DEN_NTSC;

		assign word_pal[i]   = (WP > 64'hffff) ? 17'h10000 : 17'(WP);
		assign word_ntsc[i]  = (WN > 64'hffff) ? 17'h10000 : 17'(WN);
		assign first_tab[i]  = mvpa_pkg::NAME_A[S];
		assign second_tab[i] = mvpa_pkg::NAME_B[S];
		assign octave_tab[i] = mvpa_pkg::CH_ZERO + 7'(Q);
	end

	logic [16:0] word_sel;
	assign word_sel = std_sel ? word_ntsc[note] : word_pal[note];

	always_ff @(posedge clk) begin
		word_q     <= word_sel[15:0];
		too_high_q <= word_sel[16];
		first_q    <= first_tab[note];
		second_q   <= second_tab[note];
		octave_q   <= octave_tab[note];
	end

endmodule

// ===== bench/tb_midi_poly_voice_allocator_core.sv =====
// tb_midi_poly_voice_allocator_core: self-checking bench for the voice allocator core
// depends on mvpa_pkg and midi_poly_voice_allocator_core; no other files
`timescale 1ns / 100ps

module tb_midi_poly_voice_allocator_core;

	localparam int unsigned VOICE_COUNT = 3;
	localparam int unsigned PAL_HZ      = 985248;
	localparam int unsigned NTSC_HZ     = 1022727;
	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned PHASE_ITEMS = 320;
	localparam int unsigned SETTLE_CYCLES = 10;

	// 2^(s/12) in unsigned q8.24, one entry per semitone above a
	localparam logic [31:0] SEMITONE_Q24 [12] = '{
		32'd16777216, 32'd17774841, 32'd18831788, 32'd19951585,
		32'd21137968, 32'd22394897, 32'd23726566, 32'd25137421,
		32'd26632170, 32'd28215802, 32'd29893600, 32'd31671166
	};

	// note name letters: ' ' or 'a'..'g' first, letter or '#' second
	localparam logic [6:0] LEAD_CHAR [12] = '{
		7'h20, 7'h61, 7'h20, 7'h20, 7'h63, 7'h20,
		7'h64, 7'h20, 7'h20, 7'h66, 7'h20, 7'h67
	};
	localparam logic [6:0] TAIL_CHAR [12] = '{
		7'h61, 7'h23, 7'h62, 7'h63, 7'h23, 7'h64,
		7'h23, 7'h65, 7'h66, 7'h23, 7'h67, 7'h23
	};

	typedef struct {
		logic       cmd;
		logic [6:0] note;
	} note_event_t;

	typedef struct {
		mvpa_pkg::event_t ev;
		logic [1:0]       voice;
		logic [15:0]      word;
		logic             gate;
		logic [6:0]       first;
		logic [6:0]       second;
		logic [6:0]       octave;
		logic             flag;
	} voice_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_data = 1'b0;
	logic        start = 1'b0;
	logic        cmd = mvpa_pkg::CMD_NOTE_ON;
	logic [6:0]  note = '0;
	logic        busy;
	logic        done;
	logic [2:0]  event_res;
	logic [1:0]  voice;
	logic [15:0] freq_word;
	logic        gate;
	logic [6:0]  name_first;
	logic [6:0]  name_second;
	logic [6:0]  octave_char;
	logic        out_of_voices;

	midi_poly_voice_allocator_core #(
		.VOICES        (VOICE_COUNT),
		.PAL_CLOCK_HZ  (PAL_HZ),
		.NTSC_CLOCK_HZ (NTSC_HZ)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.note          (note),
		.done          (done),
		.event_res     (event_res),
		.voice         (voice),
		.freq_word     (freq_word),
		.gate          (gate),
		.name_first    (name_first),
		.name_second   (name_second),
		.octave_char   (octave_char),
		.out_of_voices (out_of_voices)
	);

	// mirror of the allocator state, updated as items are taken
	logic        ntsc_sel = 1'b0;
	logic        slot_busy [VOICE_COUNT];
	logic [7:0]  slot_note [VOICE_COUNT];
	logic        pool_full = 1'b0;

	note_event_t   note_events [$];     // items waiting to be driven
	voice_report_t awaited_reports [$]; // predicted results, oldest first
	logic [6:0]    held_notes [$];      // notes the stimulus believes are sounding

	int unsigned items_issued = 0;
	int unsigned results_seen = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	logic        took_item = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// oscillator word: 440 * 2^((n-60)/12) * 2^24 / bus clock, truncated
	function automatic logic [31:0] oscillator_word(logic [7:0] n, logic ntsc);
		longint unsigned bus_hz;
		longint unsigned prod;
		bus_hz = ntsc ? longint'(NTSC_HZ) : longint'(PAL_HZ);
		prod = (64'd440 * longint'(SEMITONE_Q24[n % 12])) << (n / 12);
		return 32'(prod / (64'd32 * bus_hz));
	endfunction

	// works out the report of one item and advances the mirrored state
	function automatic voice_report_t predict_report(logic c, logic [6:0] nt);
		voice_report_t r;
		logic [7:0]    n;
		logic [31:0]   w;
		int            slot;
		n = 8'(nt) + 8'(mvpa_pkg::NOTE_OFFSET);
		slot = -1;
		r.ev = mvpa_pkg::EV_NO_VOICE;
		r.voice = '0;
		r.word = '0;
		r.gate = 1'b0;
		r.first = '0;
		r.second = '0;
		r.octave = '0;
		if (c == mvpa_pkg::CMD_NOTE_ON) begin
			for (int v = VOICE_COUNT - 1; v >= 0; v--)
				if (!slot_busy[v])
					slot = v;
			if (slot < 0) begin
				// every voice sounding: flag sticks until the next note-off
				pool_full = 1'b1;
				r.ev = mvpa_pkg::EV_OUT_VOICE;
			end else begin
				w = oscillator_word(n, ntsc_sel);
				if (w > 32'hffff) begin
					// word does not fit, no voice is taken and too-high is reported
					r.ev = mvpa_pkg::EV_TOO_HIGH;
				end else begin
					slot_busy[slot] = 1'b1;
					slot_note[slot] = n;
					r.ev = mvpa_pkg::EV_STARTED;
					r.voice = 2'(slot);
					r.word = w[15:0];
					r.gate = 1'b1;
					r.first = LEAD_CHAR[n % 12];
					r.second = TAIL_CHAR[n % 12];
					r.octave = mvpa_pkg::CH_ZERO + 7'(n / 12);
				end
			end
		end else begin
			pool_full = 1'b0;
			for (int v = VOICE_COUNT - 1; v >= 0; v--)
				if (slot_busy[v] && slot_note[v] == n)
					slot = v;
			if (slot >= 0) begin
				slot_busy[slot] = 1'b0;
				r.ev = mvpa_pkg::EV_RELEASED;
				r.voice = 2'(slot);
				r.first = mvpa_pkg::CH_DASH;
				r.second = mvpa_pkg::CH_DASH;
				r.octave = mvpa_pkg::CH_SPACE;
			end
		end
		r.flag = pool_full;
		return r;
	endfunction

	task automatic check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	// monitor: check results, then record the item taken at this edge
	always @(posedge clk) begin : watch_results
		voice_report_t want;
		took_item <= start && !busy;
		if (done) begin
			results_seen++;
			if (awaited_reports.size() == 0) begin
				error_count++;
				$display("%0t: result with none expected, expected nothing, got event %0d",
					$time, event_res);
			end else begin
				want = awaited_reports.pop_front();
				check_field("event_res", want.ev, event_res);
				check_field("voice", want.voice, voice);
				check_field("freq_word", want.word, freq_word);
				check_field("gate", want.gate, gate);
				check_field("name_first", want.first, name_first);
				check_field("name_second", want.second, name_second);
				check_field("octave_char", want.octave, octave_char);
				check_field("out_of_voices", want.flag, out_of_voices);
			end
		end
		if (arst_n && start && !busy)
			awaited_reports.push_back(predict_report(cmd, note));
	end

	// driver: bursts of items with random gaps, start held until taken
	always @(negedge clk) begin : drive_items
		note_event_t it;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took_item) begin
			// item still waiting for the block, keep it on the ports
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (note_events.size() > 0) begin
			it = note_events.pop_front();
			cmd <= it.cmd;
			note <= it.note;
			start <= 1'b1;
			if (burst_left == 0)
				burst_left = $urandom_range(1, 24);
			burst_left--;
			if (burst_left == 0) begin
				// one burst in four runs straight into the next one
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				burst_left = $urandom_range(1, 24);
			end
		end else begin
			start <= 1'b0;
		end
	end

	// watchdog against a hung handshake or a lost result
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic queue_item(logic c, logic [6:0] nt);
		note_event_t it;
		it.cmd = c;
		it.note = nt;
		note_events.push_back(it);
		items_issued++;
	endtask

	// block until every issued item has produced its result
	task automatic wait_idle();
		while (results_seen != items_issued)
			@(negedge clk);
	endtask

	task automatic set_video_standard(logic ntsc);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= ntsc;
		ntsc_sel = ntsc;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= 1'b0;
	endtask

	// mostly note-on / note-off pairs on sounding notes, with some stray releases
	task automatic queue_random_notes(int unsigned count);
		int unsigned pick;
		int unsigned idx;
		logic [6:0]  nt;
		for (int unsigned i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// high notes hit the word limit, so keep most of them playable
				if ($urandom_range(0, 3) == 0)
					nt = 7'($urandom_range(0, 127));
				else if ($urandom_range(0, 3) == 0)
					nt = 7'($urandom_range(40, 43));
				else
					nt = 7'($urandom_range(0, 94));
				held_notes.push_back(nt);
				if (held_notes.size() > 8)
					void'(held_notes.pop_front());
				queue_item(mvpa_pkg::CMD_NOTE_ON, nt);
			end else if (pick < 90 && held_notes.size() > 0) begin
				idx = $urandom_range(0, held_notes.size() - 1);
				nt = held_notes[idx];
				held_notes.delete(idx);
				queue_item(mvpa_pkg::CMD_NOTE_OFF, nt);
			end else begin
				queue_item(mvpa_pkg::CMD_NOTE_OFF, 7'($urandom_range(0, 127)));
			end
		end
	endtask

	initial begin : stimulus
		for (int v = 0; v < VOICE_COUNT; v++) begin
			slot_busy[v] = 1'b0;
			slot_note[v] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, pal after reset
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd0);     // lowest note, voice 0
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd127);   // highest note, word too big
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd94);    // last note that fits on pal
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd95);    // first note too high on pal
		queue_item(mvpa_pkg::CMD_NOTE_OFF, 7'd50);   // release with no voice holding it
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd0);     // duplicate note takes another voice
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd60);    // pool full
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd61);    // still full, flag stays set
		queue_item(mvpa_pkg::CMD_NOTE_OFF, 7'd0);    // lowest duplicate goes first
		queue_item(mvpa_pkg::CMD_NOTE_OFF, 7'd0);    // then the other copy
		queue_item(mvpa_pkg::CMD_NOTE_OFF, 7'd0);    // nothing left holding it
		queue_item(mvpa_pkg::CMD_NOTE_OFF, 7'd94);
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd57);    // plain name a, no sharp
		queue_item(mvpa_pkg::CMD_NOTE_OFF, 7'd57);
		wait_idle();

		// directed, ntsc moves the word limit up by one semitone
		set_video_standard(1'b1);
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd95);
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd96);
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd127);
		queue_item(mvpa_pkg::CMD_NOTE_OFF, 7'd127);
		queue_item(mvpa_pkg::CMD_NOTE_OFF, 7'd95);
		queue_item(mvpa_pkg::CMD_NOTE_ON, 7'd1);
		queue_item(mvpa_pkg::CMD_NOTE_OFF, 7'd1);
		wait_idle();

		// random phases, switching the bus clock between them
		for (int p = 0; p < 4; p++) begin
			set_video_standard(p[0] ? 1'b1 : 1'b0);
			queue_random_notes(PHASE_ITEMS);
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && awaited_reports.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
